[hdl/arl_pkg.sv]
// ----------------------------------------------------------------------------
// arl_pkg
// Shared constants, types and helpers of the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package arl_pkg;

  // Geometry of the screen and of the input coordinates
  localparam int SCREEN_SIZE   = 64;
  localparam int SUBPIXEL_BITS = 8;
  localparam int COORD_IN_W    = 14;

  // Internal fixed point: coordinates Q6.16, intercept signed Q8.16
  localparam int FRAC_W  = 16;
  localparam int CW      = 22;
  localparam int IW      = 24;
  localparam int SLOPE_W = 18;
  localparam int QW      = 17;
  localparam int DIST_W  = 17;
  localparam int PROD_W  = SLOPE_W + DIST_W;
  localparam int COV_W   = 9;
  localparam int PIX_W   = 7;
  localparam int ROW_W   = 8;
  localparam int RGBA_W  = 32;

  localparam logic [CW:0]          HALF_Q16  = (CW+1)'(32768);
  localparam logic [SLOPE_W-1:0]   ONE_Q16   = SLOPE_W'(65536);
  localparam logic [COV_W-1:0]     COV_FULL  = COV_W'(256);

  // Stream and configuration widths
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);
  localparam logic [PIX_W-1:0]     SCREEN_RESET      = PIX_W'(64);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new line item
    logic swap;        // steep-axis decision
    logic order;       // endpoint ordering, deltas
    logic div_start;   // launch the slope division
    logic latch_g;     // capture the signed slope
    logic end_mul;     // slope times end distance
    logic end_add;     // end intercept
    logic end_cov;     // end coverage weighting
    logic end_sel;     // 0: first end, 1: last end
    logic emit_first;  // push first end column
    logic emit_walk;   // push one walk column
    logic emit_last;   // push last end column
  } arl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_busy;
    logic pair_free;
    logic walk_done;
  } arl_status_t;

  // One column result before shading
  typedef struct packed {
    logic [RGBA_W-1:0]       color;
    logic                    swapped;
    logic [PIX_W-1:0]        col;
    logic signed [ROW_W-1:0] row;
    logic [COV_W-1:0]        cov_a;
    logic [COV_W-1:0]        cov_b;
    logic                    last;
  } arl_pair_t;

  // Saturate an input coordinate and widen it to Q6.16
  function automatic logic [CW-1:0] widen(input logic [COORD_IN_W-1:0] v);
    logic [CW-1:0] ext;
    logic [CW-1:0] top;
    top = CW'(SCREEN_SIZE - 1) << SUBPIXEL_BITS;
    ext = CW'(v);
    if (ext > top) begin
      ext = top;
    end
    return ext << (FRAC_W - SUBPIXEL_BITS);
  endfunction

  // Scale every channel by (1 - coverage), truncated
  function automatic logic [RGBA_W-1:0] shade(input logic [RGBA_W-1:0] color,
                                               input logic [COV_W-1:0] cov);
    logic [COV_W-1:0]   keep;
    logic [RGBA_W-1:0]  res;
    logic [COV_W+7:0]   prod;
    keep = COV_FULL - cov;
    res  = '0;
    for (int i = 0; i < 4; i++) begin
      prod = (COV_W+8)'(color[8*i +: 8]) * (COV_W+8)'(keep);
      res[8*i +: 8] = prod[15:8];
    end
    return res;
  endfunction

endpackage

[hdl/arl_div.sv]
// ----------------------------------------------------------------------------
// arl_div
// Restoring divider for the slope: quotient of (num << 16) / den, one
// quotient bit per cycle. Requires num <= den.
// ----------------------------------------------------------------------------
module arl_div import arl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] num,
  input  logic [CW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [CW:0]      rem_r, rem_nxt;
  logic [QW-1:0]    quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             ge;
  logic [CW:0]      diff;

  // One trial subtraction per cycle
  always_comb begin
    ge       = rem_r >= {1'b0, den};
    diff     = rem_r - {1'b0, den};
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = {1'b0, num};
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = (ge ? diff : rem_r) << 1;
      quot_nxt = {quot_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

[hdl/arl_dp.sv]
// ----------------------------------------------------------------------------
// arl_dp
// Datapath: endpoint set-up, slope division, end column weighting, the
// intercept walk, shading, clipping and the output register.
// ----------------------------------------------------------------------------
module arl_dp import arl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  arl_cmd_t               cmd,
  output arl_status_t            status,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PIX_W-1:0]       cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  // Screen size registers
  logic [PIX_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_RESET;
      height_r <= SCREEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == REG_SCREEN_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Captured item
  logic [CW-1:0]     p0x_r, p0y_r, p1x_r, p1y_r;
  logic [RGBA_W-1:0] color_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0x_r   <= widen(in_tdata[13:0]);
      p0y_r   <= widen(in_tdata[27:14]);
      p1x_r   <= widen(in_tdata[41:28]);
      p1y_r   <= widen(in_tdata[55:42]);
      color_r <= in_tdata[87:56];
    end
  end

  // Steep-axis swap
  logic [CW-1:0] adx_s, ady_s;
  logic          swapped_r;
  logic [CW-1:0] a0_r, b0_r, a1_r, b1_r;

  assign adx_s = (p1x_r > p0x_r) ? p1x_r - p0x_r : p0x_r - p1x_r;
  assign ady_s = (p1y_r > p0y_r) ? p1y_r - p0y_r : p0y_r - p1y_r;

  always_ff @(posedge clk) begin
    if (cmd.swap) begin
      swapped_r <= ady_s > adx_s;
      a0_r      <= (ady_s > adx_s) ? p0y_r : p0x_r;
      b0_r      <= (ady_s > adx_s) ? p0x_r : p0y_r;
      a1_r      <= (ady_s > adx_s) ? p1y_r : p1x_r;
      b1_r      <= (ady_s > adx_s) ? p1x_r : p1y_r;
    end
  end

  // Endpoint ordering along the major axis, deltas for the division
  logic          a_gt, b_gt;
  logic [CW-1:0] x0_r, y0_r, x1_r, y1_r, dx_r, ady_r;
  logic          dy_neg_r;

  assign a_gt = a0_r > a1_r;
  assign b_gt = b1_r > b0_r;

  always_ff @(posedge clk) begin
    if (cmd.order) begin
      x0_r     <= a_gt ? a1_r : a0_r;
      y0_r     <= a_gt ? b1_r : b0_r;
      x1_r     <= a_gt ? a0_r : a1_r;
      y1_r     <= a_gt ? b0_r : b1_r;
      dx_r     <= a_gt ? a0_r - a1_r : a1_r - a0_r;
      ady_r    <= b_gt ? b1_r - b0_r : b0_r - b1_r;
      dy_neg_r <= a_gt ? b_gt : (b0_r > b1_r);
    end
  end

  // End column geometry, settles while the division runs
  logic [CW:0]               xh0, xh1;
  logic [PIX_W-1:0]          c1_r, c2_r;
  logic signed [DIST_W-1:0]  d1_r, d2_r;
  logic [COV_W-1:0]          gap1_r, gap2_r;

  assign xh0 = {1'b0, x0_r} + HALF_Q16;
  assign xh1 = {1'b0, x1_r} + HALF_Q16;

  always_ff @(posedge clk) begin
    c1_r   <= xh0[FRAC_W +: PIX_W];
    c2_r   <= xh1[FRAC_W +: PIX_W];
    d1_r   <= $signed(DIST_W'(32768)) - $signed({1'b0, xh0[FRAC_W-1:0]});
    d2_r   <= $signed(DIST_W'(32768)) - $signed({1'b0, xh1[FRAC_W-1:0]});
    gap1_r <= COV_FULL - {1'b0, xh0[15:8]};
    gap2_r <= {1'b0, xh1[15:8]};
  end

  // Slope division
  logic          div_busy;
  logic [QW-1:0] div_quot;

  arl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (ady_r),
    .den   (dx_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  logic signed [SLOPE_W-1:0] g_r;
  logic [SLOPE_W-1:0]        q_ext;

  assign q_ext = {1'b0, div_quot};

  always_ff @(posedge clk) begin
    if (cmd.latch_g) begin
      if (dx_r == '0) begin
        g_r <= $signed(ONE_Q16);
      end else begin
        g_r <= dy_neg_r ? -$signed(q_ext) : $signed(q_ext);
      end
    end
  end

  // End intercepts: multiply, then add, then weight by the gap
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [IW-1:0]       ye_r;
  logic signed [DIST_W-1:0]   dsel;
  logic [CW-1:0]              ysel;
  logic [COV_W-1:0]           gsel;
  logic [7:0]                 fe;
  logic [COV_W-1:0]           rfe;
  logic [2*COV_W-1:0]         wa, wb;

  assign dsel = cmd.end_sel ? d2_r : d1_r;
  assign ysel = cmd.end_sel ? y1_r : y0_r;
  assign gsel = cmd.end_sel ? gap2_r : gap1_r;
  assign fe   = ye_r[15:8];
  assign rfe  = COV_FULL - {1'b0, fe};
  assign wa   = (2*COV_W)'(rfe) * (2*COV_W)'(gsel);
  assign wb   = (2*COV_W)'(fe) * (2*COV_W)'(gsel);

  logic signed [ROW_W-1:0] row1_r, row2_r;
  logic [COV_W-1:0]        cov1a_r, cov1b_r, cov2a_r, cov2b_r;
  logic signed [IW-1:0]    inter_r;
  logic [PIX_W-1:0]        walk_col_r;

  always_ff @(posedge clk) begin
    if (cmd.end_mul) begin
      prod_r <= g_r * dsel;
    end
    if (cmd.end_add) begin
      ye_r <= $signed({2'b00, ysel}) + IW'(prod_r >>> FRAC_W);
    end
    if (cmd.end_cov) begin
      if (cmd.end_sel) begin
        row2_r  <= ye_r[IW-1:FRAC_W];
        cov2a_r <= wa[COV_W+7:8];
        cov2b_r <= wb[COV_W+7:8];
      end else begin
        row1_r  <= ye_r[IW-1:FRAC_W];
        cov1a_r <= wa[COV_W+7:8];
        cov1b_r <= wb[COV_W+7:8];
        inter_r <= ye_r + IW'(g_r);
      end
    end
    // Walk along the major axis
    if (cmd.emit_first) begin
      walk_col_r <= c1_r + PIX_W'(1);
    end else if (cmd.emit_walk) begin
      walk_col_r <= walk_col_r + PIX_W'(1);
      inter_r    <= inter_r + IW'(g_r);
    end
  end

  // Pair stage
  arl_pair_t pair_r, pair_nxt;
  logic      pair_v_r;
  logic      out_v_r;
  logic      advance;
  logic [7:0] fw;

  assign advance = !out_v_r || out_tready;
  assign fw      = inter_r[15:8];

  always_comb begin
    pair_nxt         = pair_r;
    pair_nxt.color   = color_r;
    pair_nxt.swapped = swapped_r;
    if (cmd.emit_first) begin
      pair_nxt.col   = c1_r;
      pair_nxt.row   = row1_r;
      pair_nxt.cov_a = cov1a_r;
      pair_nxt.cov_b = cov1b_r;
      pair_nxt.last  = 1'b0;
    end else if (cmd.emit_walk) begin
      pair_nxt.col   = walk_col_r;
      pair_nxt.row   = inter_r[IW-1:FRAC_W];
      pair_nxt.cov_a = COV_FULL - {1'b0, fw};
      pair_nxt.cov_b = {1'b0, fw};
      pair_nxt.last  = 1'b0;
    end else begin
      pair_nxt.col   = c2_r;
      pair_nxt.row   = row2_r;
      pair_nxt.cov_a = cov2a_r;
      pair_nxt.cov_b = cov2b_r;
      pair_nxt.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_first || cmd.emit_walk || cmd.emit_last) begin
      pair_r <= pair_nxt;
    end
  end

  // Shading and clipping into the output register
  logic signed [ROW_W:0] cs, rs, rs1, ax, ay, bx, by;
  logic                  vis_a, vis_b;

  assign cs  = $signed({2'b00, pair_r.col});
  assign rs  = $signed({pair_r.row[ROW_W-1], pair_r.row});
  assign rs1 = rs + $signed((ROW_W+1)'(1));
  assign ax  = pair_r.swapped ? rs  : cs;
  assign ay  = pair_r.swapped ? cs  : rs;
  assign bx  = pair_r.swapped ? rs1 : cs;
  assign by  = pair_r.swapped ? cs  : rs1;

  assign vis_a = !ax[ROW_W] && !ay[ROW_W] &&
                 (ax[ROW_W-1:0] < {1'b0, width_r}) && (ay[ROW_W-1:0] < {1'b0, height_r});
  assign vis_b = !bx[ROW_W] && !by[ROW_W] &&
                 (bx[ROW_W-1:0] < {1'b0, width_r}) && (by[ROW_W-1:0] < {1'b0, height_r});

  logic [OUT_TDATA_W-1:0] tdata_r;
  logic [OUT_TUSER_W-1:0] tuser_r;
  logic                   tlast_r;

  always_ff @(posedge clk) begin
    if (advance && pair_v_r) begin
      tdata_r <= {4'b0000,
                  shade(pair_r.color, pair_r.cov_b),
                  shade(pair_r.color, pair_r.cov_a),
                  by[PIX_W-1:0], bx[PIX_W-1:0], ay[PIX_W-1:0], ax[PIX_W-1:0]};
      tuser_r <= {vis_b, vis_a};
      tlast_r <= pair_r.last;
    end
  end

  // Valid flags of the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.emit_first || cmd.emit_walk || cmd.emit_last) begin
        pair_v_r <= 1'b1;
      end else if (advance) begin
        pair_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= pair_v_r;
      end
    end
  end

  assign status.div_busy  = div_busy;
  assign status.pair_free = !pair_v_r || advance;
  assign status.walk_done = walk_col_r >= c2_r;

  assign out_tvalid = out_v_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;
  assign out_tlast  = tlast_r;

endmodule

[hdl/arl_ctrl.sv]
// ----------------------------------------------------------------------------
// arl_ctrl
// Sequencer: set-up of one line, the two end columns and the column walk.
// ----------------------------------------------------------------------------
module arl_ctrl import arl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  arl_status_t status,
  output arl_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SWAP     = 4'd1;
  localparam logic [3:0] S_ORDER    = 4'd2;
  localparam logic [3:0] S_DIV_GO   = 4'd3;
  localparam logic [3:0] S_DIV_WAIT = 4'd4;
  localparam logic [3:0] S_E1_MUL   = 4'd5;
  localparam logic [3:0] S_E1_ADD   = 4'd6;
  localparam logic [3:0] S_E1_COV   = 4'd7;
  localparam logic [3:0] S_E2_MUL   = 4'd8;
  localparam logic [3:0] S_E2_ADD   = 4'd9;
  localparam logic [3:0] S_E2_COV   = 4'd10;
  localparam logic [3:0] S_EMIT1    = 4'd11;
  localparam logic [3:0] S_WALK     = 4'd12;
  localparam logic [3:0] S_EMIT2    = 4'd13;

  logic [3:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd.swap  = 1'b1;
        state_nxt = S_ORDER;
      end
      S_ORDER: begin
        cmd.order = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          cmd.latch_g = 1'b1;
          state_nxt   = S_E1_MUL;
        end
      end
      S_E1_MUL: begin
        cmd.end_mul = 1'b1;
        state_nxt   = S_E1_ADD;
      end
      S_E1_ADD: begin
        cmd.end_add = 1'b1;
        state_nxt   = S_E1_COV;
      end
      S_E1_COV: begin
        cmd.end_cov = 1'b1;
        state_nxt   = S_E2_MUL;
      end
      S_E2_MUL: begin
        cmd.end_mul = 1'b1;
        cmd.end_sel = 1'b1;
        state_nxt   = S_E2_ADD;
      end
      S_E2_ADD: begin
        cmd.end_add = 1'b1;
        cmd.end_sel = 1'b1;
        state_nxt   = S_E2_COV;
      end
      S_E2_COV: begin
        cmd.end_cov = 1'b1;
        cmd.end_sel = 1'b1;
        state_nxt   = S_EMIT1;
      end
      S_EMIT1: begin
        if (status.pair_free) begin
          cmd.emit_first = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        if (status.walk_done) begin
          state_nxt = S_EMIT2;
        end else if (status.pair_free) begin
          cmd.emit_walk = 1'b1;
        end
      end
      S_EMIT2: begin
        if (status.pair_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

endmodule

[hdl/antialiased_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_core
// Xiaolin Wu antialiased line rasterizer, one column pair per result.
// ----------------------------------------------------------------------------
// One input item is a line segment with Q6.8 endpoints and an RGBA color; it
// yields one result per major-axis column in ascending order, the last one
// marked by out_tlast (two results when both ends share one column). The
// first result of a line is offered after swap, ordering and divider launch,
// the wait on the slope division (17 quotient bits at one per cycle, then
// the slope latch), the two end columns and the first end column into the
// pair stage; it then passes the pair and output registers. The walk then
// hands one result per cycle to the pair stage while the pair stage is free,
// and hands no result when it leaves the walk. Output stalls hold the walk
// once the pair and output registers are full. The next line is accepted
// once the last column of the current one has been handed to the output
// stages. The user must write the screen size registers through the cfg
// port only while no line is in flight; the block itself does not enforce
// it.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_core import arl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // start_x, start_y, end_x, end_y (14 b each), red, green, blue, alpha
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // first_px_x, first_px_y, second_px_x, second_px_y (7 b each),
  // first_px_rgba, second_px_rgba (32 b each), zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // first_px_visible, second_px_visible
  output logic [OUT_TUSER_W-1:0] out_tuser,
  // last_of_line
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PIX_W-1:0]       cfg_data
);

  arl_cmd_t    cmd;
  arl_status_t status;

  arl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  arl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Register writes never stall
  assign cfg_ready = 1'b1;

endmodule

[verif/line_column_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_column_checker
// Watches the line, result and register channels of the rasterizer core,
// works out the column pairs every accepted line must produce and compares
// each accepted result against the oldest outstanding one.
// ----------------------------------------------------------------------------
module line_column_checker import arl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PIX_W-1:0]       cfg_data,
  output int                     check_failures,
  output int                     columns_pending
);

  localparam longint UNIT      = longint'(1) << FRAC_W;
  localparam longint HALF      = UNIT >> 1;
  localparam longint COORD_TOP = longint'(SCREEN_SIZE - 1) << SUBPIXEL_BITS;

  // One column result: the pixel pair straddling the line
  typedef struct packed {
    logic [PIX_W-1:0]  ax;
    logic [PIX_W-1:0]  ay;
    logic [PIX_W-1:0]  bx;
    logic [PIX_W-1:0]  by;
    logic [RGBA_W-1:0] a_rgba;
    logic [RGBA_W-1:0] b_rgba;
    logic              a_vis;
    logic              b_vis;
    logic              last;
  } column_pair_t;

  column_pair_t     expected_columns[$];
  logic [PIX_W-1:0] width_reg;
  logic [PIX_W-1:0] height_reg;

  initial begin
    check_failures  = 0;
    columns_pending = 0;
  end

  // Saturate an input coordinate and move it to 16 fraction bits
  function automatic longint to_q16(input logic [COORD_IN_W-1:0] v);
    longint w;
    w = v;
    if (w > COORD_TOP) begin
      w = COORD_TOP;
    end
    return w << (FRAC_W - SUBPIXEL_BITS);
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Coverage fraction: bits 15..8 of a Q.16 value
  function automatic longint frac8(input longint v);
    return (v >> 8) & 255;
  endfunction

  // Every channel times (1 - coverage), truncated
  function automatic logic [RGBA_W-1:0] dim_color(input logic [RGBA_W-1:0] rgba,
                                                  input longint cov);
    logic [RGBA_W-1:0] res;
    longint            keep;
    longint            ch;
    keep = 256 - cov;
    for (int k = 0; k < 4; k++) begin
      ch = rgba[8*k +: 8];
      res[8*k +: 8] = 8'((ch * keep) >> 8);
    end
    return res;
  endfunction

  function automatic logic on_raster(input longint px, input longint py);
    longint w;
    longint h;
    w = width_reg;
    h = height_reg;
    return (px >= 0) && (py >= 0) && (px < w) && (py < h);
  endfunction

  // Queue one pair; minor row goes to y unless the axes are swapped
  function automatic void push_pair(input bit steep, input logic [RGBA_W-1:0] rgba,
                                    input longint col, input longint row,
                                    input longint cov_a, input longint cov_b,
                                    input bit last);
    column_pair_t p;
    longint       ax, ay, bx, by;
    ax = steep ? row : col;
    ay = steep ? col : row;
    bx = steep ? row + 1 : col;
    by = steep ? col : row + 1;
    p.ax     = ax[PIX_W-1:0];
    p.ay     = ay[PIX_W-1:0];
    p.bx     = bx[PIX_W-1:0];
    p.by     = by[PIX_W-1:0];
    p.a_rgba = dim_color(rgba, cov_a);
    p.b_rgba = dim_color(rgba, cov_b);
    p.a_vis  = on_raster(ax, ay);
    p.b_vis  = on_raster(bx, by);
    p.last   = last;
    expected_columns.push_back(p);
  endfunction

  // Walk one line along its major axis and queue every column pair
  function automatic void trace_line(input logic [IN_TDATA_W-1:0] d);
    longint            maj0, min0, maj1, min1, tmp;
    longint            d_maj, d_min, grad, col_lo, col_hi;
    longint            y_end, row, frac, wgt, icpt;
    bit                steep;
    logic [RGBA_W-1:0] rgba;
    maj0 = to_q16(d[13:0]);
    min0 = to_q16(d[27:14]);
    maj1 = to_q16(d[41:28]);
    min1 = to_q16(d[55:42]);
    rgba = d[87:56];

    steep = magnitude(min1 - min0) > magnitude(maj1 - maj0);
    if (steep) begin
      tmp = maj0; maj0 = min0; min0 = tmp;
      tmp = maj1; maj1 = min1; min1 = tmp;
    end
    if (maj0 > maj1) begin
      tmp = maj0; maj0 = maj1; maj1 = tmp;
      tmp = min0; min0 = min1; min1 = tmp;
    end
    d_maj = maj1 - maj0;
    d_min = min1 - min0;
    grad  = (d_maj == 0) ? UNIT : (d_min * UNIT) / d_maj;

    // first end column, weighted by the gap to the next pixel edge
    col_lo = (maj0 + HALF) >> FRAC_W;
    y_end  = min0 + ((grad * (col_lo * UNIT - maj0)) >>> FRAC_W);
    row    = y_end >>> FRAC_W;
    frac   = frac8(y_end);
    wgt    = 256 - frac8(maj0 + HALF);
    push_pair(steep, rgba, col_lo, row, ((256 - frac) * wgt) >> 8,
              (frac * wgt) >> 8, 1'b0);
    icpt = y_end + grad;

    // interior columns
    col_hi = (maj1 + HALF) >> FRAC_W;
    for (longint c = col_lo + 1; c < col_hi; c++) begin
      row  = icpt >>> FRAC_W;
      frac = frac8(icpt);
      push_pair(steep, rgba, c, row, 256 - frac, frac, 1'b0);
      icpt += grad;
    end

    // last end column
    y_end = min1 + ((grad * (col_hi * UNIT - maj1)) >>> FRAC_W);
    row   = y_end >>> FRAC_W;
    frac  = frac8(y_end);
    wgt   = frac8(maj1 + HALF);
    push_pair(steep, rgba, col_hi, row, ((256 - frac) * wgt) >> 8,
              (frac * wgt) >> 8, 1'b1);
  endfunction

  function automatic void note(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    check_failures++;
    $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
  endfunction

  // Compare one accepted result with the oldest outstanding pair
  function automatic void check_column();
    column_pair_t got;
    column_pair_t want;
    got.ax     = out_tdata[6:0];
    got.ay     = out_tdata[13:7];
    got.bx     = out_tdata[20:14];
    got.by     = out_tdata[27:21];
    got.a_rgba = out_tdata[59:28];
    got.b_rgba = out_tdata[91:60];
    got.a_vis  = out_tuser[0];
    got.b_vis  = out_tuser[1];
    got.last   = out_tlast;
    if (expected_columns.size() == 0) begin
      check_failures++;
      $display("%0t: unexpected result, expected none, got %0h / %0h / %0b",
               $time, out_tdata, out_tuser, out_tlast);
      return;
    end
    want = expected_columns.pop_front();
    if (got.ax !== want.ax)         note("first_px_x", want.ax, got.ax);
    if (got.ay !== want.ay)         note("first_px_y", want.ay, got.ay);
    if (got.bx !== want.bx)         note("second_px_x", want.bx, got.bx);
    if (got.by !== want.by)         note("second_px_y", want.by, got.by);
    if (got.a_rgba !== want.a_rgba) note("first_px_rgba", want.a_rgba, got.a_rgba);
    if (got.b_rgba !== want.b_rgba) note("second_px_rgba", want.b_rgba, got.b_rgba);
    if (got.a_vis !== want.a_vis)   note("first_px_visible", want.a_vis, got.a_vis);
    if (got.b_vis !== want.b_vis)   note("second_px_visible", want.b_vis, got.b_vis);
    if (got.last !== want.last)     note("last_of_line", want.last, got.last);
  endfunction

  // Results first: a line accepted this cycle cannot answer in the same cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = SCREEN_RESET;
      height_reg = SCREEN_RESET;
      expected_columns.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_column();
      end
      if (in_tvalid && in_tready) begin
        trace_line(in_tdata);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH: begin
            width_reg = cfg_data;
          end
          REG_SCREEN_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    columns_pending = expected_columns.size();
  end

endmodule

[verif/tb_antialiased_line_rasterizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_antialiased_line_rasterizer_core
// Drives line items and screen size writes into the rasterizer core with
// random gaps and output stalls, one long output hold-off included; the
// column checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_antialiased_line_rasterizer_core;
  import arl_pkg::*;

  localparam int COORD_MAX       = (1 << COORD_IN_W) - 1;
  localparam int COORD_TOP       = (SCREEN_SIZE - 1) << SUBPIXEL_BITS;
  localparam int N_PHASES        = 7;
  localparam int LINES_PER_PHASE = 33;
  localparam int HOLD_AT         = 30;
  localparam int HOLD_CYCLES     = 600;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 60;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [PIX_W-1:0]       cfg_data;

  int check_failures;
  int columns_pending;
  int lines_sent;
  int quiet_cycles;

  antialiased_line_rasterizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  line_column_checker column_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .check_failures  (check_failures),
    .columns_pending (columns_pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Fields from the lowest bit: start x/y, end x/y, then r,g,b,a
  function automatic logic [IN_TDATA_W-1:0] line_item(input int sx, input int sy,
                                                      input int ex, input int ey,
                                                      input logic [31:0] rgba);
    return {rgba, 14'(ey), 14'(ex), 14'(sy), 14'(sx)};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_line();
    int          sx, sy, ex, ey, kind, span, r;
    logic [31:0] rgba;
    kind = $urandom_range(0, 9);
    sx = $urandom_range(0, COORD_TOP);
    sy = $urandom_range(0, COORD_TOP);
    ex = $urandom_range(0, COORD_TOP);
    ey = $urandom_range(0, COORD_TOP);
    case (kind)
      4, 5: begin
        // short segment near its start
        ex = clamp_coord(sx + $urandom_range(0, 3072) - 1536);
        ey = clamp_coord(sy + $urandom_range(0, 3072) - 1536);
      end
      6: begin
        // full field range, saturation included
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        ex = $urandom_range(0, COORD_MAX);
        ey = $urandom_range(0, COORD_MAX);
      end
      7: begin
        if ($urandom_range(0, 1)) ey = sy;
        else ex = sx;
      end
      8: begin
        // a point or both ends in one column
        ex = clamp_coord(sx + $urandom_range(0, 128) - 64);
        ey = clamp_coord(sy + $urandom_range(0, 128) - 64);
      end
      9: begin
        // exact diagonal
        span = $urandom_range(0, COORD_TOP / 2);
        sx = $urandom_range(0, COORD_TOP - span);
        ex = sx + span;
        ey = (sy >= span) ? sy - span : sy + span;
      end
      default: begin
      end
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) rgba = '0;
    else if (r == 1) rgba = '1;
    else rgba = $urandom;
    return line_item(sx, sy, ex, ey, rgba);
  endfunction

  // Offer one line after an optional gap and hold it until taken
  task automatic send_line(input logic [IN_TDATA_W-1:0] d, input int gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = IN_TDATA_W'({$urandom, $urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    in_tdata  = d;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    lines_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result sink: random stalls, stretches at full rate, one long hold-off
  initial begin : sink
    int  stall_left;
    int  run_left;
    bit  hold_done;
    out_tready = 1'b0;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && lines_sent >= HOLD_AT) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done  = 1'b1;
        stall_left = 0;
        run_left   = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        stall_left = idle_len();
        run_left   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20)
                                                : $urandom_range(100, 300);
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        run_left--;
      end
    end
  end

  // No handshake on any channel for too long ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] widths [N_PHASES];
    logic [PIX_W-1:0] heights[N_PHASES];
    quiet_cycles = 0;
    lines_sent   = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SCREEN_WIDTH;
    cfg_data     = '0;
    widths  = '{7'd64, 7'd1, 7'd64, 7'd0, 7'd127, 7'(($urandom_range(1, 64))), 7'd37};
    heights = '{7'd64, 7'd64, 7'd1, 7'd0, 7'd127, 7'(($urandom_range(1, 64))), 7'd20};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed lines at the reset screen size
    send_line(line_item(0, 0, 0, 0, 32'hFFFF_FFFF), 0);                 // point, dx zero
    send_line(line_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h0), idle_len());
    send_line(line_item(0, 0, COORD_MAX, 0, 32'h8040_20FF), idle_len()); // full row
    send_line(line_item(0, 0, 0, COORD_MAX, 32'hFF00_FF00), idle_len()); // vertical
    send_line(line_item(COORD_TOP, COORD_TOP, 0, 0, 32'h00FF_00FF), 0);  // reversed
    send_line(line_item(0, COORD_TOP, COORD_TOP, 0, 32'h7F7F_7F7F), idle_len());
    send_line(line_item('h0180, 'h0280, 'h2A40, 'h0F13, 32'h1234_5678), idle_len());
    send_line(line_item('h1000, 'h3E00, 'h0C80, 'h0100, 32'hFEDC_BA98), 0); // steep, reversed
    send_line(line_item('h0080, 'h0080, 'h0380, 'h0200, 32'hFFFF_FFFF), idle_len());
    send_line(line_item('h0500, 'h0520, 'h0570, 'h0560, 32'hA5A5_5A5A), idle_len());
    send_line(line_item('h0000, 'h0400, 'h0890, 'h0000, 32'hFFFF_FFFF), 0); // row below zero
    send_line(line_item('h0000, 'h3F00, 'h1000, 'h3F00, 32'hC0C0_C0C0), idle_len());
    send_line(line_item('h3F00, 'h0000, 'h3F00, 'h1000, 32'h0101_0101), idle_len());
    send_line(line_item('h0100, 'h0200, 'h0900, 'h0A00, 32'h8000_0080), 0); // diagonal

    // Random lines under several screen sizes
    for (int p = 0; p < N_PHASES; p++) begin
      while (columns_pending != 0) @(negedge clk);
      write_reg(REG_SCREEN_WIDTH, widths[p]);
      write_reg(REG_SCREEN_HEIGHT, heights[p]);
      if (p == 2 || p == 5) begin
        write_reg(REG_UNMAPPED_LO, 7'($urandom));
        write_reg(REG_UNMAPPED_HI, 7'($urandom));
      end
      for (int k = 0; k < LINES_PER_PHASE; k++) begin
        send_line(random_line(), idle_len());
      end
    end
    in_tvalid = 1'b0;

    while (columns_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (check_failures == 0 && columns_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
